[design/crce_pkg.sv]
// ----------------------------------------------------------------------------
// crce_pkg: shared types and constants for the programmable CRC block
// Payload structs for both channels, the control word of the cell chain
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package crce_pkg;

  localparam int unsigned REM_W = 32;
  localparam int unsigned DEG_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_TAPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEG_W-1:0] GEN_DEGREE_RST = 6'd3;
  localparam logic [REM_W-1:0] GEN_TAPS_RST   = 32'd3;

  typedef struct packed {
    logic data_bit;
    logic msg_end;
  } in_t;

  typedef struct packed {
    logic             out_bit;
    logic             out_last;
    logic             error_flag;
    logic [REM_W-1:0] remainder_value;
  } out_t;

  // Control word broadcast along the cell chain
  typedef struct packed {
    logic step;   // every cell takes its lower neighbor's bit (the lowest cell takes din)
    logic clear;  // every cell goes to zero
    logic fb;     // feedback bit, xored in where a tap is set
    logic din;    // bit entering the lowest cell
  } crce_ctrl_t;

endpackage

[design/crce_cell.sv]
// ----------------------------------------------------------------------------
// crce_cell: one bit of the remainder register
// Takes the bit of its lower neighbor, xors in the feedback where its
// generator tap is set, and reads as zero above the active degree.
// ----------------------------------------------------------------------------
module crce_cell (
  input  logic               clk,
  input  crce_pkg::crce_ctrl_t ctrl,
  input  logic               en,
  input  logic               tap,
  input  logic               prev,
  output logic               q,
  output logic               q_step
);

  logic q_reg;
  logic q_next;

  // Value of this bit after one step, zero above the active degree
  assign q_step = en & (prev ^ (ctrl.fb & tap));

  // Next value of this bit
  always_comb begin
    if (ctrl.clear) begin
      q_next = 1'b0;
    end else if (ctrl.step) begin
      q_next = q_step;
    end else begin
      q_next = q_reg;
    end
  end

  // Hold the bit
  always_ff @(posedge clk) begin
    q_reg <= q_next;
  end

  assign q = q_reg;

endmodule

[design/crce_chain.sv]
// ----------------------------------------------------------------------------
// crce_chain: row of remainder cells
// Each cell hands its bit to the next one up every step; the lowest cell
// takes the input bit. Exposes the current contents of the row and the
// contents after one step.
// ----------------------------------------------------------------------------
module crce_chain #(
  parameter int unsigned CELLS = 32
) (
  input  logic                 clk,
  input  crce_pkg::crce_ctrl_t ctrl,
  input  logic [CELLS-1:0]     en,
  input  logic [CELLS-1:0]     taps,
  output logic [CELLS-1:0]     cur,
  output logic [CELLS-1:0]     nxt
);

  logic [CELLS-1:0] prev;

  // Lowest cell takes the input bit, the others their lower neighbor
  assign prev = {cur[CELLS-1:0] << 1} | CELLS'(ctrl.din);

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    crce_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .en     (en[i]),
      .tap    (taps[i]),
      .prev   (prev[i]),
      .q      (cur[i]),
      .q_step (nxt[i])
    );
  end

endmodule

[design/crce_outbuf.sv]
// ----------------------------------------------------------------------------
// crce_outbuf: two-entry output buffer
// Output register plus one skid entry, so the producer can push one more
// item while the downstream side stalls.
// ----------------------------------------------------------------------------
module crce_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crce_pkg::out_t  push_data,
  output logic            space,
  output logic            out_valid,
  input  logic            out_stall,
  output crce_pkg::out_t  out_data
);

  logic [1:0]     count;
  crce_pkg::out_t ent0;
  crce_pkg::out_t ent1;
  logic           pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign space     = (count != 2'd2) || pop;
  assign out_data  = ent0;

  // Track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Move entries: head advances on pop, new item lands behind the last one
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        ent0 <= push_data;
      end else begin
        ent0 <= ent1;
      end
      if (push && count == 2'd2) begin
        ent1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        ent0 <= push_data;
      end else begin
        ent1 <= push_data;
      end
    end
  end

endmodule

[design/programmable_crc_encode_check_top.sv]
// ----------------------------------------------------------------------------
// Output: each result is registered in the output buffer before it shows.
// Throughput: one data bit per cycle; in encode mode the message end is
// followed by one trailer bit per check bit (the clamped degree) while the
// remainder shifts out of the cell row and the input is stalled. A full
// two-entry output buffer that is not being drained also stalls input and trailer.
// Reset: synchronous; clears the cell row and control state, loads degree 3,
// taps 3 and encode mode.
// ----------------------------------------------------------------------------
// programmable_crc_encode_check_top: bit-serial CRC encoder and checker
// Programmable generator of degree 1 to the smaller of MAX_DEGREE and 32, held in a row of cells.
// ----------------------------------------------------------------------------
module programmable_crc_encode_check_top #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  crce_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output crce_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [crce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crce_pkg::REM_W-1:0]          cfg_wdata
);

  localparam int unsigned CELLS = (MAX_DEGREE < crce_pkg::REM_W) ? MAX_DEGREE
                                                                 : crce_pkg::REM_W;

  typedef enum logic {ST_DATA, ST_TRAIL} state_t;

  state_t                        state;
  logic [crce_pkg::DEG_W-1:0]    gen_degree;
  logic [crce_pkg::REM_W-1:0]    gen_taps;
  logic                          check_mode;
  logic [crce_pkg::DEG_W-1:0]    cnt;
  logic [CELLS-1:0]              rem_hold;

  logic [crce_pkg::DEG_W-1:0]    deg;
  logic [CELLS-1:0]              en;
  logic [CELLS-1:0]              sel;
  logic [CELLS-1:0]              cur;
  logic [CELLS-1:0]              nxt;
  logic                          top_bit;
  logic                          trailing;
  logic                          space;
  logic                          accept;
  logic                          push;
  crce_pkg::out_t                push_data;
  crce_pkg::crce_ctrl_t          ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_degree <= crce_pkg::GEN_DEGREE_RST;
      gen_taps   <= crce_pkg::GEN_TAPS_RST;
      check_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crce_pkg::CFG_GEN_DEGREE: gen_degree <= cfg_wdata[crce_pkg::DEG_W-1:0];
        crce_pkg::CFG_GEN_TAPS:   gen_taps   <= cfg_wdata;
        crce_pkg::CFG_CHECK_MODE: check_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the degree to 1..CELLS
  always_comb begin
    if (gen_degree == '0) begin
      deg = crce_pkg::DEG_W'(1);
    end else if (gen_degree > crce_pkg::DEG_W'(CELLS)) begin
      deg = crce_pkg::DEG_W'(CELLS);
    end else begin
      deg = gen_degree;
    end
  end

  // Active cells and the top cell of the current degree
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      en[i]  = (crce_pkg::DEG_W'(i) < deg);
      sel[i] = (crce_pkg::DEG_W'(i + 1) == deg);
    end
  end

  assign top_bit  = |(cur & sel);
  assign trailing = (state == ST_TRAIL);
  assign in_stall = trailing || !space;
  assign accept   = in_valid && !in_stall;

  // Drive the cell row; reset and a checked message end clear it
  always_comb begin
    ctrl.clear = rst || (accept && check_mode && in_data.msg_end);
    ctrl.step  = (accept && !(check_mode && in_data.msg_end)) || (trailing && space);
    if (trailing) begin
      ctrl.fb  = 1'b0;
      ctrl.din = 1'b0;
    end else if (check_mode) begin
      ctrl.fb  = top_bit;
      ctrl.din = in_data.data_bit;
    end else begin
      ctrl.fb  = top_bit ^ in_data.data_bit;
      ctrl.din = 1'b0;
    end
  end

  crce_chain #(.CELLS(CELLS)) u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .en   (en),
    .taps (gen_taps[CELLS-1:0]),
    .cur  (cur),
    .nxt  (nxt)
  );

  // Build the result item: trailer bit, check report or echo
  always_comb begin
    push = (trailing && space) || (accept && (!check_mode || in_data.msg_end));
    if (trailing) begin
      push_data.out_bit         = top_bit;
      push_data.out_last        = (cnt == crce_pkg::DEG_W'(1));
      push_data.error_flag      = 1'b0;
      push_data.remainder_value = crce_pkg::REM_W'(rem_hold);
    end else if (check_mode) begin
      push_data.out_bit         = 1'b0;
      push_data.out_last        = 1'b1;
      push_data.error_flag      = |(nxt & en);
      push_data.remainder_value = crce_pkg::REM_W'(nxt & en);
    end else begin
      push_data.out_bit         = in_data.data_bit;
      push_data.out_last        = 1'b0;
      push_data.error_flag      = 1'b0;
      push_data.remainder_value = '0;
    end
  end

  // Sequence the trailer after an encoded message
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DATA;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_DATA: begin
          if (accept && !check_mode && in_data.msg_end) begin
            state <= ST_TRAIL;
            cnt   <= deg;
          end
        end
        ST_TRAIL: begin
          if (space) begin
            cnt <= cnt - crce_pkg::DEG_W'(1);
            if (cnt == crce_pkg::DEG_W'(1)) begin
              state <= ST_DATA;
            end
          end
        end
        default: state <= ST_DATA;
      endcase
    end
  end

  // Keep the final remainder for the trailer items
  always_ff @(posedge clk) begin
    if (accept && !check_mode && in_data.msg_end) begin
      rem_hold <= nxt & en;
    end
  end

  crce_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/programmable_crc_encode_check_top_tb.sv]
// ----------------------------------------------------------------------------
// programmable_crc_encode_check_top_tb: self-checking bench for the CRC block
// Feeds message bits through a bursty sender and collects results with a
// stalling receiver. Each accepted bit is run through a local bit-serial
// divider that tracks the generator settings, and each accepted result is
// compared field by field with the oldest prediction. A directed part covers
// the degree limits, both modes, short messages and settings changed in the
// middle of a message. Random phases follow, each with new settings.
// ----------------------------------------------------------------------------
module programmable_crc_encode_check_top_tb;

  localparam int unsigned MAX_DEG = 32;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 17;
  localparam logic [crce_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Stall styles of the receiver
  typedef enum int unsigned {
    STALL_NONE,
    STALL_HALF,
    STALL_SPARSE,
    STALL_HEAVY
  } stall_style_e;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  crce_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  crce_pkg::out_t                 out_data;
  logic                           cfg_we = 1'b0;
  logic [crce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [crce_pkg::REM_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the generator settings and the running remainder
  logic [crce_pkg::DEG_W-1:0]     gen_degree_sh = crce_pkg::GEN_DEGREE_RST;
  logic [crce_pkg::REM_W-1:0]     gen_taps_sh = crce_pkg::GEN_TAPS_RST;
  logic                           check_mode_sh = 1'b0;
  logic [crce_pkg::REM_W-1:0]     crc_state = '0;

  crce_pkg::in_t                  bit_stream_q[$];
  crce_pkg::out_t                 crc_results_q[$];
  crce_pkg::out_t                 want;

  int unsigned          burst_left = 1;
  int unsigned          gap_left = 0;
  stall_style_e         stall_style = STALL_NONE;
  int unsigned          style_left = 0;
  logic                 stall_next;

  int unsigned          cycle_count = 0;
  int unsigned          err_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          msgs_sent = 0;
  int unsigned          results_checked = 0;
  int unsigned          settings_count = 0;

  programmable_crc_encode_check_top #(
    .MAX_DEGREE (MAX_DEG)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Divide one bit and queue the results it causes
  task automatic crc_predict(input crce_pkg::in_t item);
    int unsigned                deg;
    logic [63:0]                wide_mask;
    logic [crce_pkg::REM_W-1:0] mask;
    logic [crce_pkg::REM_W-1:0] taps;
    logic [crce_pkg::REM_W-1:0] rem;
    logic                       top;
    crce_pkg::out_t             res;
    deg = gen_degree_sh;
    if (deg < 1) deg = 1;
    if (deg > MAX_DEG) deg = MAX_DEG;
    if (deg > crce_pkg::REM_W) deg = crce_pkg::REM_W;
    wide_mask = (64'd1 << deg) - 64'd1;
    mask = wide_mask[crce_pkg::REM_W-1:0];
    taps = gen_taps_sh & mask;
    rem = crc_state & mask;
    top = rem[deg-1];
    if (check_mode_sh) begin
      rem = ((rem << 1) | crce_pkg::REM_W'(item.data_bit)) & mask;
      if (top) rem = rem ^ taps;
    end else begin
      rem = (rem << 1) & mask;
      if (top ^ item.data_bit) rem = rem ^ taps;
    end
    rem = rem & mask;
    if (check_mode_sh) begin
      if (item.msg_end) begin
        res.out_bit = 1'b0;
        res.out_last = 1'b1;
        res.error_flag = (rem != '0);
        res.remainder_value = rem;
        crc_results_q.push_back(res);
      end
    end else begin
      // echo the data bit, then append the check bits at message end
      res.out_bit = item.data_bit;
      res.out_last = 1'b0;
      res.error_flag = 1'b0;
      res.remainder_value = '0;
      crc_results_q.push_back(res);
      if (item.msg_end) begin
        for (int i = 0; i < deg; i++) begin
          res.out_bit = rem[deg-1-i];
          res.out_last = (i + 1 == deg);
          res.error_flag = 1'b0;
          res.remainder_value = rem;
          crc_results_q.push_back(res);
        end
      end
    end
    if (item.msg_end) msgs_sent++;
    crc_state = item.msg_end ? '0 : rem;
  endtask

  // Driver: launch queued items in bursts, hold a stalled item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        crc_predict(in_data);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bit_stream_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= bit_stream_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results and pick the next stall
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crc_results_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: bit %0d last %0d err %0d rem %08h",
                     out_data.out_bit, out_data.out_last, out_data.error_flag,
                     out_data.remainder_value);
        end else begin
          want = crc_results_q.pop_front();
          results_checked++;
          if (out_data.out_bit !== want.out_bit ||
              out_data.out_last !== want.out_last ||
              out_data.error_flag !== want.error_flag ||
              out_data.remainder_value !== want.remainder_value) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch: exp bit %0d last %0d err %0d rem %08h,",
                        " got bit %0d last %0d err %0d rem %08h"},
                       want.out_bit, want.out_last, want.error_flag,
                       want.remainder_value,
                       out_data.out_bit, out_data.out_last, out_data.error_flag,
                       out_data.remainder_value);
          end
        end
      end
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(20, 80);
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_NONE:   stall_next = 1'b0;
        STALL_HALF:   stall_next = 1'($urandom_range(0, 1));
        STALL_SPARSE: stall_next = ($urandom_range(0, 3) == 0);
        default:      stall_next = ($urandom_range(0, 7) < 6);
      endcase
      out_stall <= stall_next;
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, crc_results_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_bit(input logic data_bit, input logic msg_end);
    crce_pkg::in_t item;
    item.data_bit = data_bit;
    item.msg_end = msg_end;
    bit_stream_q.push_back(item);
  endtask

  // Wait until every item is sent and every result is in, then settle
  task automatic drain_block();
    while (bit_stream_q.size() != 0 || in_valid || crc_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [crce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crce_pkg::REM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      crce_pkg::CFG_GEN_DEGREE: gen_degree_sh = val[crce_pkg::DEG_W-1:0];
      crce_pkg::CFG_GEN_TAPS:   gen_taps_sh = val;
      crce_pkg::CFG_CHECK_MODE: check_mode_sh = val[0];
      default: ;
    endcase
  endtask

  // Write all three registers, optionally poke the unused index too
  task automatic configure(input logic [crce_pkg::REM_W-1:0] degree,
                           input logic [crce_pkg::REM_W-1:0] taps,
                           input logic mode, input logic poke_unused);
    write_reg(crce_pkg::CFG_GEN_DEGREE, degree);
    write_reg(crce_pkg::CFG_GEN_TAPS, taps);
    write_reg(crce_pkg::CFG_CHECK_MODE, {31'($urandom), mode});
    if (poke_unused) write_reg(CFG_UNUSED, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Stimulus
  initial begin
    int unsigned count;
    int unsigned len;
    int unsigned pick;
    logic [crce_pkg::REM_W-1:0] degree;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: degree 3, taps 3, encode
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b1);
    drain_block();

    // degree zero acts as degree one; taps above the degree are ignored
    configure(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b1);
    drain_block();

    // oversized degree saturates to the full width
    configure(32'd63, 32'h04C1_1DB7, 1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b1);
    drain_block();

    // check mode on messages shorter than the generator
    configure(32'd32, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b1);
    drain_block();

    // degree changed in the middle of a message
    configure(32'd8, 32'h0000_0007, 1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    drain_block();
    configure(32'd5, 32'h0000_0007, 1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b1, 1'b1);
    drain_block();

    // mode changed in the middle of a message
    configure(32'd4, 32'h0000_0003, 1'b1, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    drain_block();
    configure(32'd4, 32'h0000_0003, 1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b1, 1'b1);
    drain_block();

    // random phases: new settings, mostly whole messages, some noise
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) degree = 32'd0;
      else if (pick == 1) degree = 32'd32;
      else if (pick == 2) degree = $urandom_range(33, 63);
      else degree = $urandom_range(1, 8);
      configure(degree, $urandom, 1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) begin
          push_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          count++;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            push_bit(1'($urandom_range(0, 1)), (i + 1 == len));
          count += len;
        end
      end
      drain_block();
    end

    // count any prediction left over as errors
    if (crc_results_q.size() != 0) begin
      err_count += crc_results_q.size();
      $display("%0d predicted results never arrived", crc_results_q.size());
    end
    $display("Sent %0d bits in %0d messages under %0d generator settings,",
             items_sent, msgs_sent, settings_count + 1);
    $display("checked %0d results in both modes, degrees from 1 up to the saturated 32",
             results_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[programmable_crc_encode_check_top.f]
design/crce_pkg.sv
design/crce_cell.sv
design/crce_chain.sv
design/crce_outbuf.sv
design/programmable_crc_encode_check_top.sv
sim/programmable_crc_encode_check_top_tb.sv
